FILE: design/sawes_pkg.sv
// Package for the stop-and-wait event sender: codes, item types and
// reset constants shared by the interfaces, the front and back sections.
// No dependencies.
`default_nettype none

package sawes_pkg;

    // Field widths
    localparam int unsigned CMD_W     = 2;
    localparam int unsigned HANDLE_W  = 16;
    localparam int unsigned NONCE_W   = 16;
    localparam int unsigned KIND_W    = 2;
    localparam int unsigned ATTEMPT_W = 8;
    localparam int unsigned TICKS_W   = 16;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 16;

    // Input command codes
    localparam logic [CMD_W-1:0] CMD_ENQUEUE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ACK     = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK    = 2'd2;

    // Result kind codes
    localparam logic [KIND_W-1:0] RES_NONCE  = 2'd0;
    localparam logic [KIND_W-1:0] RES_TX     = 2'd1;
    localparam logic [KIND_W-1:0] RES_DROP   = 2'd2;
    localparam logic [KIND_W-1:0] RES_REJECT = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RETX_TICKS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TX     = 2'd1;

    // Configuration reset values
    localparam logic [TICKS_W-1:0]   RETX_TICKS_RST = 16'd1000;
    localparam logic [ATTEMPT_W-1:0] MAX_TX_RST     = 8'd5;

    // Operations handed from front to back
    typedef enum logic [1:0] {
        OP_ENQUEUE,
        OP_ACK,
        OP_TICK
    } t_op_kind;

    typedef struct packed {
        t_op_kind              kind;
        logic [HANDLE_W-1:0]   handle;
        logic [NONCE_W-1:0]    nonce;
        logic                  success;
    } t_op;

    // One queued entry: nonce in the upper half, handle in the lower
    typedef struct packed {
        logic [NONCE_W-1:0]  nonce;
        logic [HANDLE_W-1:0] handle;
    } t_entry;

    typedef struct packed {
        logic [KIND_W-1:0]    kind;
        logic [NONCE_W-1:0]   nonce;
        logic [HANDLE_W-1:0]  handle;
        logic [ATTEMPT_W-1:0] attempt;
        logic                 last;
    } t_result;

    // Back section sequencer
    typedef enum logic [1:0] {
        ST_EXEC,
        ST_READ,
        ST_PROMOTE
    } t_state;

endpackage

`default_nettype wire

FILE: design/sawes_ifs.sv
// Channel interfaces of the stop-and-wait event sender: input items,
// result items and configuration writes. Depends on sawes_pkg.
`default_nettype none

interface sawes_in_if;
    import sawes_pkg::*;
    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    command;
    logic [HANDLE_W-1:0] payload_handle;
    logic [NONCE_W-1:0]  ack_nonce;
    logic                ack_success;

    modport source (output valid, command, payload_handle, ack_nonce, ack_success,
                    input ready);
    modport sink   (input valid, command, payload_handle, ack_nonce, ack_success,
                    output ready);
endinterface

interface sawes_out_if;
    import sawes_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [KIND_W-1:0]    result_kind;
    logic [NONCE_W-1:0]   packet_nonce;
    logic [HANDLE_W-1:0]  packet_handle;
    logic [ATTEMPT_W-1:0] attempt_number;
    logic                 last_result;

    modport source (output valid, result_kind, packet_nonce, packet_handle,
                    attempt_number, last_result, input ready);
    modport sink   (input valid, result_kind, packet_nonce, packet_handle,
                    attempt_number, last_result, output ready);
endinterface

interface sawes_cfg_if;
    import sawes_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] reg_index;
    logic [CFG_DAT_W-1:0] wr_data;

    modport source (output valid, reg_index, wr_data, input ready);
    modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

`default_nettype wire

FILE: design/sawes_front.sv
// Front section: accepts input transactions, classifies the command and
// buffers operations in a two-entry queue. Depends on sawes_pkg, sawes_ifs.
`default_nettype none

module sawes_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    sawes_in_if.sink           i_in,
    output sawes_pkg::t_op     o_op,
    output logic               o_op_valid,
    input  wire logic          i_op_pop
);
    import sawes_pkg::*;

    t_op        r_q [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_cnt;
    logic       push;
    logic       accept;
    t_op        op_in;

    // Classify the incoming command; the unused code is taken and dropped
    always_comb begin
        op_in.handle  = i_in.payload_handle;
        op_in.nonce   = i_in.ack_nonce;
        op_in.success = i_in.ack_success;
        op_in.kind    = OP_TICK;
        push          = 1'b0;
        unique case (i_in.command)
            CMD_ENQUEUE: begin
                op_in.kind = OP_ENQUEUE;
                push       = 1'b1;
            end
            CMD_ACK: begin
                op_in.kind = OP_ACK;
                push       = 1'b1;
            end
            CMD_TICK: begin
                op_in.kind = OP_TICK;
                push       = 1'b1;
            end
            default: push = 1'b0;
        endcase
    end

    assign i_in.ready = (r_cnt != 2'd2);
    assign accept     = i_in.valid && i_in.ready;
    assign o_op_valid = (r_cnt != 2'd0);
    assign o_op       = r_q[r_rd_ptr];

    // Queue payload
    always_ff @(posedge i_clk) begin
        if (accept && push) begin
            r_q[r_wr_ptr] <= op_in;
        end
    end

    // Queue pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_cnt    <= 2'd0;
        end else begin
            if (accept && push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_op_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_cnt <= r_cnt + {1'b0, (accept && push)} - {1'b0, i_op_pop};
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_op_pop |-> o_op_valid)
        else $error("pop from empty operation queue");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0) |-> (r_wr_ptr == r_rd_ptr))
        else $error("operation queue pointers disagree with empty count");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2 && !i_op_pop) |=> (r_cnt == 2'd2))
        else $error("full operation queue lost an entry");

endmodule

`default_nettype wire

FILE: design/sawes_back.sv
// Back section: entry FIFO memory, pending-entry state, retransmit timer,
// configuration registers and the result register. Depends on sawes_pkg, sawes_ifs.
`default_nettype none

module sawes_back #(
    parameter int unsigned QUEUE_DEPTH = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  sawes_pkg::t_op     i_op,
    input  wire logic          i_op_valid,
    output logic               o_op_pop,
    sawes_cfg_if.sink          i_cfg,
    sawes_out_if.source        o_out
);
    import sawes_pkg::*;

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Entry memory
    t_entry r_mem [QUEUE_DEPTH];
    t_entry r_rd_data;

    t_state               r_state;
    t_state               n_state;
    logic [PTR_W-1:0]     r_head;
    logic [PTR_W-1:0]     r_tail;
    logic [CNT_W-1:0]     r_count;
    logic [NONCE_W-1:0]   r_next_nonce;
    logic                 r_pend_valid;
    t_entry               r_pend_entry;
    logic [ATTEMPT_W-1:0] r_tx;
    logic [TICKS_W-1:0]   r_elapsed;
    logic [TICKS_W-1:0]   r_retx_ticks;
    logic [ATTEMPT_W-1:0] r_max_tx;
    logic                 r_out_valid;
    t_result              r_out;

    // Effect of the current operation
    logic                 ex_emit;
    t_result              ex_res;
    logic                 ex_pend_valid;
    logic [ATTEMPT_W-1:0] ex_tx;
    logic [TICKS_W-1:0]   ex_elapsed;
    logic                 ex_enq;
    logic [CNT_W-1:0]     ex_count;
    logic                 ex_promote;
    logic [ATTEMPT_W-1:0] tx_sat;
    logic [TICKS_W-1:0]   el_sat;
    logic                 q_full;

    // Sequencer outputs
    logic                 slot_free;
    logic                 ex_go;
    logic                 promo_go;
    logic                 out_load;
    t_result              out_data;

    assign slot_free = !r_out_valid || o_out.ready;
    assign q_full    = (r_count == CNT_W'(QUEUE_DEPTH));
    assign tx_sat    = (r_tx == '1) ? r_tx : r_tx + 1'b1;
    assign el_sat    = (r_elapsed == '1) ? r_elapsed : r_elapsed + 1'b1;

    // Work out what the operation at the queue head does
    always_comb begin
        ex_emit       = 1'b0;
        ex_res        = '0;
        ex_pend_valid = r_pend_valid;
        ex_tx         = r_tx;
        ex_elapsed    = r_elapsed;
        ex_enq        = 1'b0;
        unique case (i_op.kind)
            OP_ENQUEUE: begin
                ex_emit       = 1'b1;
                ex_res.nonce  = r_next_nonce;
                ex_res.handle = i_op.handle;
                if (q_full) begin
                    ex_res.kind = RES_REJECT;
                end else begin
                    ex_res.kind = RES_NONCE;
                    ex_enq      = 1'b1;
                end
            end
            OP_ACK: begin
                if (r_pend_valid && r_pend_entry.nonce == i_op.nonce) begin
                    if (i_op.success) begin
                        ex_pend_valid = 1'b0;
                    end else begin
                        ex_emit        = 1'b1;
                        ex_res.kind    = RES_TX;
                        ex_res.nonce   = r_pend_entry.nonce;
                        ex_res.handle  = r_pend_entry.handle;
                        ex_res.attempt = tx_sat;
                        ex_tx          = tx_sat;
                        ex_elapsed     = '0;
                    end
                end
            end
            OP_TICK: begin
                if (r_pend_valid) begin
                    ex_elapsed    = el_sat;
                    ex_res.nonce  = r_pend_entry.nonce;
                    ex_res.handle = r_pend_entry.handle;
                    if (el_sat >= r_retx_ticks) begin
                        ex_emit = 1'b1;
                        if (r_tx < r_max_tx) begin
                            ex_res.kind    = RES_TX;
                            ex_res.attempt = tx_sat;
                            ex_tx          = tx_sat;
                            ex_elapsed     = '0;
                        end else begin
                            ex_res.kind    = RES_DROP;
                            ex_res.attempt = r_tx;
                            ex_pend_valid  = 1'b0;
                        end
                    end
                end
            end
            default: ex_emit = 1'b0;
        endcase
        ex_count    = r_count + CNT_W'(ex_enq);
        ex_promote  = !ex_pend_valid && (ex_count != '0);
        ex_res.last = !ex_promote;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_EXEC: begin
                if (i_op_valid && (!ex_emit || slot_free) && ex_promote) begin
                    n_state = ST_READ;
                end
            end
            ST_READ:    n_state = ST_PROMOTE;
            ST_PROMOTE: begin
                if (slot_free) begin
                    n_state = ST_EXEC;
                end
            end
            default:    n_state = ST_EXEC;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        ex_go    = 1'b0;
        promo_go = 1'b0;
        out_load = 1'b0;
        out_data = ex_res;
        unique case (r_state)
            ST_EXEC: begin
                ex_go    = i_op_valid && (!ex_emit || slot_free);
                out_load = ex_go && ex_emit;
            end
            ST_PROMOTE: begin
                promo_go         = slot_free;
                out_load         = slot_free;
                out_data.kind    = RES_TX;
                out_data.nonce   = r_rd_data.nonce;
                out_data.handle  = r_rd_data.handle;
                out_data.attempt = ATTEMPT_W'(1);
                out_data.last    = 1'b1;
            end
            default: begin
                ex_go    = 1'b0;
                promo_go = 1'b0;
            end
        endcase
    end

    assign o_op_pop = ex_go;

    // Entry memory: write at tail, registered read at head
    always_ff @(posedge i_clk) begin
        if (ex_go && ex_enq) begin
            r_mem[r_tail] <= '{nonce: r_next_nonce, handle: i_op.handle};
        end
        r_rd_data <= r_mem[r_head];
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_EXEC;
            r_head       <= '0;
            r_tail       <= '0;
            r_count      <= '0;
            r_next_nonce <= '0;
            r_pend_valid <= 1'b0;
            r_tx         <= '0;
            r_elapsed    <= '0;
        end else begin
            r_state <= n_state;
            if (ex_go) begin
                if (ex_enq) begin
                    r_tail       <= (r_tail == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_tail + 1'b1;
                    r_next_nonce <= r_next_nonce + 1'b1;
                end
                r_count      <= ex_count;
                r_pend_valid <= ex_pend_valid;
                r_tx         <= ex_tx;
                r_elapsed    <= ex_elapsed;
            end else if (promo_go) begin
                r_head       <= (r_head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
                r_count      <= r_count - 1'b1;
                r_pend_valid <= 1'b1;
                r_tx         <= ATTEMPT_W'(1);
                r_elapsed    <= '0;
            end
        end
    end

    // Pending entry payload
    always_ff @(posedge i_clk) begin
        if (promo_go) begin
            r_pend_entry <= r_rd_data;
        end
    end

    // Configuration registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_retx_ticks <= RETX_TICKS_RST;
            r_max_tx     <= MAX_TX_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.reg_index)
                CFG_RETX_TICKS: r_retx_ticks <= i_cfg.wr_data;
                CFG_MAX_TX:     r_max_tx     <= i_cfg.wr_data[ATTEMPT_W-1:0];
                default:        ;
            endcase
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= out_data;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.result_kind    = r_out.kind;
    assign o_out.packet_nonce   = r_out.nonce;
    assign o_out.packet_handle  = r_out.handle;
    assign o_out.attempt_number = r_out.attempt;
    assign o_out.last_result    = r_out.last;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("entry FIFO count above depth");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ) |-> (!r_pend_valid && r_count != '0))
        else $error("promotion started without a free slot or queued entry");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_head == r_tail))
        else $error("empty FIFO with head and tail apart");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.kind == RES_TX) |-> (r_out.attempt != '0))
        else $error("transmit result with zero attempt count");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        promo_go |=> (r_pend_valid && r_tx == ATTEMPT_W'(1)))
        else $error("promotion did not make the entry pending");

endmodule

`default_nettype wire

FILE: design/stop_and_wait_event_sender.sv
// Stop-and-wait event sender. Up to two items are buffered between front and
// back. An accepted item waits in the front queue until the back section
// executes it and loads its first result, if any, into the result register;
// promoting the FIFO head adds the registered entry-memory read and promote
// states. Synchronous active-low reset clears all control state and loads the
// register defaults; the entry memory is not cleared and needs no clearing pass.
`default_nettype none

module stop_and_wait_event_sender #(
    parameter int unsigned QUEUE_DEPTH = 16
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    sawes_in_if.sink    i_in,
    sawes_cfg_if.sink   i_cfg,
    sawes_out_if.source o_out
);
    import sawes_pkg::*;

    t_op  op;
    logic op_valid;
    logic op_pop;

    // Accept and classify
    sawes_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (i_in),
        .o_op       (op),
        .o_op_valid (op_valid),
        .i_op_pop   (op_pop)
    );

    // Execute against the pending entry and FIFO
    sawes_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op       (op),
        .i_op_valid (op_valid),
        .o_op_pop   (op_pop),
        .i_cfg      (i_cfg),
        .o_out      (o_out)
    );

endmodule

`default_nettype wire

FILE: sim/tb_stop_and_wait_event_sender.sv
// Testbench for stop_and_wait_event_sender: directed and random commands,
// a scoreboard class that predicts nonce, transmit, drop and reject reports.
// Depends on sawes_pkg, sawes_ifs and the design top level.
`timescale 1ns / 100ps

module tb_stop_and_wait_event_sender;
    import sawes_pkg::*;

    localparam int unsigned QDEPTH      = 16;
    localparam int          SETTLE      = 16;
    localparam int          HOLD_CYCLES = 300;
    localparam int          CYCLE_LIMIT = 1_500_000;

    // Command code the block ignores
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]    command;
        logic [HANDLE_W-1:0] handle;
        logic [NONCE_W-1:0]  ack_nonce;
        logic                ack_success;
    } t_cmd_item;

    // Tracks the sender's queue and pending entry, predicts its reports
    class arq_tracker;
        t_entry               fifo_mem[QDEPTH];
        int unsigned          head;
        int unsigned          tail;
        int unsigned          fill;
        logic [NONCE_W-1:0]   next_nonce;
        logic                 pend_valid;
        t_entry               pend_entry;
        logic [ATTEMPT_W-1:0] pend_tx;
        logic [TICKS_W-1:0]   elapsed;
        logic [TICKS_W-1:0]   retx_ticks;
        logic [ATTEMPT_W-1:0] max_tx;
        t_result              due_reports[$];
        t_result              fresh[$];
        int                   mismatches;

        function new();
            head       = 0;
            tail       = 0;
            fill       = 0;
            next_nonce = '0;
            pend_valid = 1'b0;
            pend_entry = '0;
            pend_tx    = '0;
            elapsed    = '0;
            retx_ticks = RETX_TICKS_RST;
            max_tx     = MAX_TX_RST;
            mismatches = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
            case (idx)
                CFG_RETX_TICKS: retx_ticks = data;
                CFG_MAX_TX:     max_tx = data[ATTEMPT_W-1:0];
                default: ;
            endcase
        endfunction

        function void post(logic [KIND_W-1:0] kind, t_entry e, logic [ATTEMPT_W-1:0] att);
            t_result r;
            r.kind    = kind;
            r.nonce   = e.nonce;
            r.handle  = e.handle;
            r.attempt = att;
            r.last    = 1'b0;
            fresh.insert(fresh.size(), r);
        endfunction

        function void transmit();
            if (pend_tx != '1)
                pend_tx++;
            elapsed = '0;
            post(RES_TX, pend_entry, pend_tx);
        endfunction

        // Apply one accepted command and queue the reports it causes
        function void note_command(t_cmd_item it);
            t_entry e;
            e.nonce  = next_nonce;
            e.handle = it.handle;
            fresh.delete();
            case (it.command)
                CMD_ENQUEUE: begin
                    if (fill >= QDEPTH) begin
                        post(RES_REJECT, e, '0);
                    end else begin
                        fifo_mem[tail] = e;
                        tail = (tail + 1 >= QDEPTH) ? 0 : tail + 1;
                        fill++;
                        next_nonce++;
                        post(RES_NONCE, e, '0);
                    end
                end
                CMD_ACK: begin
                    if (pend_valid && pend_entry.nonce == it.ack_nonce) begin
                        if (it.ack_success)
                            pend_valid = 1'b0;
                        else
                            transmit();
                    end
                end
                CMD_TICK: begin
                    if (pend_valid) begin
                        if (elapsed != '1)
                            elapsed++;
                        if (elapsed >= retx_ticks) begin
                            if (pend_tx < max_tx) begin
                                transmit();
                            end else begin
                                post(RES_DROP, pend_entry, pend_tx);
                                pend_valid = 1'b0;
                            end
                        end
                    end
                end
                default: return;
            endcase
            // head of the queue goes out as soon as nothing is pending
            if (!pend_valid && fill > 0) begin
                pend_entry = fifo_mem[head];
                head = (head + 1 >= QDEPTH) ? 0 : head + 1;
                fill--;
                pend_valid = 1'b1;
                pend_tx    = '0;
                elapsed    = '0;
                transmit();
            end
            if (fresh.size() > 0)
                fresh[fresh.size() - 1].last = 1'b1;
            foreach (fresh[i])
                due_reports.insert(due_reports.size(), fresh[i]);
        endfunction

        function void field_check(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                mismatches++;
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, want, got);
            end
        endfunction

        function void check_report(t_result got);
            t_result want;
            if (due_reports.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result, expected none, actual kind %0d nonce %0d",
                         $time, got.kind, got.nonce);
                return;
            end
            want = due_reports[0];
            due_reports.delete(0);
            field_check("result_kind", want.kind, got.kind);
            field_check("packet_nonce", want.nonce, got.nonce);
            field_check("packet_handle", want.handle, got.handle);
            field_check("attempt_number", want.attempt, got.attempt);
            field_check("last_result", want.last, got.last);
        endfunction

        function int outstanding();
            return due_reports.size();
        endfunction
    endclass

    logic       i_clk   = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       hold_req = 1'b0;
    logic       steady   = 1'b0;
    int         cycle_count = 0;
    t_result    seen;
    arq_tracker sb = new;

    sawes_in_if  in_ch();
    sawes_out_if out_ch();
    sawes_cfg_if cfg_ch();

    stop_and_wait_event_sender #(.QUEUE_DEPTH(QDEPTH)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    // 12 ns clock
    always begin
        #6;
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            seen.kind    = out_ch.result_kind;
            seen.nonce   = out_ch.packet_nonce;
            seen.handle  = out_ch.packet_handle;
            seen.attempt = out_ch.attempt_number;
            seen.last    = out_ch.last_result;
            sb.check_report(seen);
        end
    end

    // Result receiver: random stalls, one long hold-off on request
    initial begin : receiver
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                out_ch.ready = 1'b0;
                for (int c = 1; c < HOLD_CYCLES; c++)
                    @(negedge i_clk);
                hold_req = 1'b0;
            end else if (!steady && $urandom_range(0, 9) == 0) begin
                out_ch.ready = 1'b0;
                repeat ($urandom_range(0, 13)) @(negedge i_clk);
            end else begin
                out_ch.ready = 1'b1;
            end
        end
    end

    function automatic t_cmd_item make_cmd(logic [CMD_W-1:0] cmd, logic [HANDLE_W-1:0] handle,
                                           logic [NONCE_W-1:0] nonce, logic succ);
        t_cmd_item it;
        it.command     = cmd;
        it.handle      = handle;
        it.ack_nonce   = nonce;
        it.ack_success = succ;
        return it;
    endfunction

    // Mostly well-formed traffic: acks usually target the pending nonce
    function automatic t_cmd_item random_cmd(int enq_pct);
        t_cmd_item it;
        int        r;
        it.handle      = 16'($urandom);
        it.ack_nonce   = 16'($urandom);
        it.ack_success = 1'($urandom);
        r = $urandom_range(0, 99);
        if (r < enq_pct) begin
            it.command = CMD_ENQUEUE;
        end else if (r < enq_pct + 20) begin
            it.command = CMD_ACK;
            if (sb.pend_valid)
                it.ack_nonce = sb.pend_entry.nonce;
        end else if (r < enq_pct + 26) begin
            it.command = CMD_ACK;
        end else if (r < enq_pct + 31) begin
            it.command = CMD_UNUSED;
        end else begin
            it.command = CMD_TICK;
        end
        return it;
    endfunction

    task automatic issue_command(t_cmd_item it);
        if (!steady && $urandom_range(0, 7) == 0) begin
            @(negedge i_clk);
            in_ch.valid = 1'b0;
            repeat ($urandom_range(0, 13)) @(negedge i_clk);
        end
        @(negedge i_clk);
        in_ch.command        = it.command;
        in_ch.payload_handle = it.handle;
        in_ch.ack_nonce      = it.ack_nonce;
        in_ch.ack_success    = it.ack_success;
        in_ch.valid          = 1'b1;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        sb.note_command(it);
    endtask

    // Drain every expected report, then let the back section go idle
    task automatic quiesce();
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        while (sb.outstanding() > 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
        @(negedge i_clk);
        cfg_ch.reg_index = idx;
        cfg_ch.wr_data   = data;
        cfg_ch.valid     = 1'b1;
        @(posedge i_clk);
        while (!cfg_ch.ready)
            @(posedge i_clk);
        sb.set_register(idx, data);
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic write_settings(logic [TICKS_W-1:0] ticks, logic [ATTEMPT_W-1:0] max_tx);
        quiesce();
        write_register(CFG_RETX_TICKS, ticks);
        // upper data bits are outside the register and must be ignored
        write_register(CFG_MAX_TX, {8'($urandom), max_tx});
    endtask

    task automatic run_traffic(int count, int enq_pct);
        for (int i = 0; i < count; i++)
            issue_command(random_cmd(enq_pct));
    endtask

    initial begin : main
        in_ch.valid          = 1'b0;
        in_ch.command        = CMD_ENQUEUE;
        in_ch.payload_handle = '0;
        in_ch.ack_nonce      = '0;
        in_ch.ack_success    = 1'b0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.reg_index     = CFG_RETX_TICKS;
        cfg_ch.wr_data       = '0;

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed, reset register values
        issue_command(make_cmd(CMD_UNUSED, 16'h0000, 16'h0000, 1'b0));
        issue_command(make_cmd(CMD_TICK, 16'h1234, 16'h0000, 1'b1));   // nothing pending
        issue_command(make_cmd(CMD_ACK, 16'h0000, 16'h0000, 1'b1));    // nothing pending
        issue_command(make_cmd(CMD_ENQUEUE, 16'h0000, 16'hFFFF, 1'b1));
        issue_command(make_cmd(CMD_ENQUEUE, 16'hFFFF, 16'h0000, 1'b0));
        issue_command(make_cmd(CMD_ACK, 16'h0000, 16'h0005, 1'b1));    // nonce never issued
        issue_command(make_cmd(CMD_ACK, 16'hFFFF, 16'h0000, 1'b0));    // failure: resend
        issue_command(make_cmd(CMD_TICK, 16'h0000, 16'h0000, 1'b0));
        issue_command(make_cmd(CMD_ACK, 16'h0000, 16'h0000, 1'b1));    // release, next goes
        issue_command(make_cmd(CMD_ACK, 16'h0000, 16'h0001, 1'b1));    // release, queue empty
        issue_command(make_cmd(CMD_UNUSED, 16'hFFFF, 16'hFFFF, 1'b1));

        // Directed, lowest register values: every timeout drops
        write_settings(16'd1, 8'd1);
        issue_command(make_cmd(CMD_ENQUEUE, 16'hA5A5, 16'h0000, 1'b0));
        issue_command(make_cmd(CMD_ENQUEUE, 16'h5A5A, 16'h0000, 1'b0));
        issue_command(make_cmd(CMD_TICK, 16'h0000, 16'h0000, 1'b0));   // drop plus next send
        issue_command(make_cmd(CMD_TICK, 16'h0000, 16'h0000, 1'b0));   // drop, queue empty
        issue_command(make_cmd(CMD_ACK, 16'h0000, 16'hFFFF, 1'b0));

        // Random phases
        write_settings(16'd3, 8'd3);
        run_traffic(40, 35);

        // Out-of-range registers: zero ticks and zero transmissions
        write_settings(16'd0, 8'd0);
        run_traffic(20, 40);

        // Highest values; receiver holds off while enqueues pile up
        write_settings(16'hFFFF, 8'd255);
        hold_req = 1'b1;
        run_traffic(60, 70);

        // Transmit count saturation through failed acks, then a drop
        write_settings(16'd1, 8'd255);
        issue_command(make_cmd(CMD_ENQUEUE, 16'($urandom), 16'($urandom), 1'($urandom)));
        for (int i = 0; i < 258; i++)
            issue_command(make_cmd(CMD_ACK, 16'($urandom), sb.pend_entry.nonce, 1'b0));
        issue_command(make_cmd(CMD_TICK, 16'($urandom), 16'($urandom), 1'($urandom)));

        write_settings(16'($urandom_range(1, 5)), 8'($urandom_range(1, 4)));
        run_traffic(30, 35);

        // Last part: no idling on either side
        write_settings(16'd4, 8'd3);
        steady = 1'b1;
        run_traffic(25, 35);

        quiesce();
        if (sb.mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
